// ===== src/mcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrc_pkg
// Shared types and constants for the multi-width CRC engine: mode codes,
// polynomials, init and final xor values.
// ----------------------------------------------------------------------------
package mcrc_pkg;

   localparam int CRC_W = 64;

   typedef enum logic [1:0] {
      MODE_CRC8  = 2'd0,
      MODE_CRC32 = 2'd1,
      MODE_CRC64 = 2'd2
   } mode_type;

   localparam logic [7:0]  POLY8   = 8'h07;
   localparam logic [31:0] POLY32  = 32'h04C11DB7;
   localparam logic [63:0] POLY64  = 64'h42F0E1EBA9EA3693;

   localparam logic [7:0]  INIT8   = 8'h00;
   localparam logic [31:0] INIT32  = 32'hFFFFFFFF;
   localparam logic [63:0] INIT64  = 64'hFFFFFFFFFFFFFFFF;

   localparam logic [7:0]  XOR8    = 8'h00;
   localparam logic [31:0] XOR32   = 32'hFFFFFFFF;
   localparam logic [63:0] XOR64   = 64'hFFFFFFFFFFFFFFFF;

   function automatic logic [CRC_W-1:0] crc_init(input mode_type mode);
      logic [CRC_W-1:0] v;
      case (mode)
         MODE_CRC8:  v = {{(CRC_W-8){1'b0}}, INIT8};
         MODE_CRC32: v = {{(CRC_W-32){1'b0}}, INIT32};
         MODE_CRC64: v = INIT64;
         default:    v = {{(CRC_W-32){1'b0}}, INIT32};
      endcase
      return v;
   endfunction

endpackage

// ===== src/mcrc_fold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrc_fold
// Folds one message byte, MSB first, into the running CRC register for the
// selected mode and forms the finalized CRC value.
// ----------------------------------------------------------------------------
module mcrc_fold
   import mcrc_pkg::*;
(
   input  mode_type          mode,
   input  logic [CRC_W-1:0]  crc_cur,
   input  logic [7:0]        data_byte,
   output logic [CRC_W-1:0]  crc_next,
   output logic [CRC_W-1:0]  crc_out
);

   function automatic logic [7:0] fold8(input logic [7:0] r_in, input logic [7:0] b);
      logic [7:0] r;
      r = r_in ^ b;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ POLY8) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [31:0] fold32(input logic [31:0] r_in, input logic [7:0] b);
      logic [31:0] r;
      r = r_in ^ {b, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         r = r[31] ? ({r[30:0], 1'b0} ^ POLY32) : {r[30:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [63:0] fold64(input logic [63:0] r_in, input logic [7:0] b);
      logic [63:0] r;
      r = r_in ^ {b, 56'h0};
      for (int i = 0; i < 8; i++) begin
         r = r[63] ? ({r[62:0], 1'b0} ^ POLY64) : {r[62:0], 1'b0};
      end
      return r;
   endfunction

   logic [7:0]  f8;
   logic [31:0] f32;
   logic [63:0] f64;

   assign f8  = fold8(crc_cur[7:0], data_byte);
   assign f32 = fold32(crc_cur[31:0], data_byte);
   assign f64 = fold64(crc_cur[63:0], data_byte);

   always_comb begin
      case (mode)
         MODE_CRC8: begin
            crc_next = {{(CRC_W-8){1'b0}}, f8};
            crc_out  = {{(CRC_W-8){1'b0}}, f8 ^ XOR8};
         end
         MODE_CRC64: begin
            crc_next = f64;
            crc_out  = f64 ^ XOR64;
         end
         default: begin
            crc_next = {{(CRC_W-32){1'b0}}, f32};
            crc_out  = {{(CRC_W-32){1'b0}}, f32 ^ XOR32};
         end
      endcase
   end

endmodule

// ===== src/multi_width_crc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_width_crc_engine
// Byte-wide MSB-first CRC-8 / CRC-32 / CRC-64 engine with one result per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one message byte per beat plus a last-byte flag.
//   rsp_ channel returns, for every request beat, the finalized CRC of the
//   message so far (zero-extended to 64 bits) and a copy of the last flag.
//   csr_wr_en / csr_wr_data select the mode (0 CRC-8, 1 CRC-32, 2 CRC-64);
//   a write of 3 is ignored, any legal write reloads the CRC init value.
//   Write the mode only while no beat is in flight.
// A request beat is held in the input register, then folded into the output
//   register that drives rsp_; a stalled rsp_ keeps it in the input register.
// Throughput: one beat per cycle while rsp_ is not stalled, set by the
//   combinational byte fold in the CRC register feedback loop.
// Reset: mode returns to CRC-32, the CRC register to its all-ones init and
//   both stages are emptied.
// Stall: while rsp_stall holds a response, the input register still takes
//   one more beat; req_stall rises only once both stages are full.
// ----------------------------------------------------------------------------
module multi_width_crc_engine
   import mcrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CRC_W-1:0]  rsp_crc_value,
   output logic              rsp_crc_final,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]  out_value_ff;
   logic              out_final_ff;
   mode_type          mode_ff, mode_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;

   logic              advance;
   logic              take_req;
   logic              mode_wr;
   logic [CRC_W-1:0]  crc_next;
   logic [CRC_W-1:0]  crc_out;

   mcrc_fold u_fold (
      .mode      (mode_ff),
      .crc_cur   (crc_ff),
      .data_byte (in_byte_ff),
      .crc_next  (crc_next),
      .crc_out   (crc_out)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign mode_wr   = csr_wr_en && (csr_wr_data == MODE_CRC8 ||
                                    csr_wr_data == MODE_CRC32 ||
                                    csr_wr_data == MODE_CRC64);

   always_comb begin
      in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);
      mode_in      = mode_wr ? mode_type'(csr_wr_data) : mode_ff;
      if (mode_wr) begin
         crc_in = crc_init(mode_type'(csr_wr_data));
      end else if (advance) begin
         crc_in = in_last_ff ? crc_init(mode_ff) : crc_next;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_CRC32;
         crc_ff       <= crc_init(MODE_CRC32);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         out_value_ff <= crc_out;
         out_final_ff <= in_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_value_ff;
   assign rsp_crc_final = out_final_ff;

endmodule

// ===== tb/sv/multi_width_crc_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_width_crc_engine_tb
// Self-checking bench for the byte-serial CRC-8 / CRC-32 / CRC-64 engine.
// A tracker class folds every accepted byte into its own CRC register and
// queues the finalized value. Each response beat is compared in order. The
// run has a directed opening with extreme bytes and mid-message mode writes.
// It then sends random messages in every mode under four idle patterns, with
// one long response hold and one full drain between beats.
// ----------------------------------------------------------------------------
module multi_width_crc_engine_tb
   import mcrc_pkg::*;
();

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         SEG_COUNT      = 12;
   localparam int         SEG_BEATS      = 150;

   typedef struct {
      logic [63:0] crc;
      logic        fin;
   } crc_result_type;

   class crc_tracker;
      mode_type       mode;
      logic [63:0]    crc_reg;
      crc_result_type due_q[$];
      int             mismatches;
      int             checked;

      function new();
         mode       = MODE_CRC32;
         crc_reg    = start_value(MODE_CRC32);
         mismatches = 0;
         checked    = 0;
      endfunction

      function logic [63:0] start_value(mode_type m);
         case (m)
            MODE_CRC8:  return {56'b0, INIT8};
            MODE_CRC64: return INIT64;
            default:    return {32'b0, INIT32};
         endcase
      endfunction

      function void select_mode(logic [1:0] v);
         if (v == MODE_UNUSED) return;
         mode    = mode_type'(v);
         crc_reg = start_value(mode);
      endfunction

      function void note_byte(logic [7:0] d, logic l);
         int             w;
         logic [63:0]    poly;
         logic [63:0]    mask;
         logic [63:0]    fxor;
         logic [63:0]    r;
         logic           top;
         crc_result_type e;
         case (mode)
            MODE_CRC8: begin
               w = 8; poly = {56'b0, POLY8}; mask = 64'hFF; fxor = {56'b0, XOR8};
            end
            MODE_CRC64: begin
               w = 64; poly = POLY64; mask = '1; fxor = XOR64;
            end
            default: begin
               w = 32; poly = {32'b0, POLY32}; mask = 64'hFFFF_FFFF;
               fxor = {32'b0, XOR32};
            end
         endcase
         r = crc_reg ^ ({56'b0, d} << (w - 8));
         for (int i = 0; i < 8; i++) begin
            top = r[w-1];
            r   = (r << 1) & mask;
            if (top) r ^= poly;
         end
         e.crc   = (r ^ fxor) & mask;
         e.fin   = l;
         crc_reg = l ? start_value(mode) : r;
         due_q.push_back(e);
      endfunction

      function void check_crc(logic [63:0] v, logic f);
         crc_result_type e;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response crc=%h final=%b", v, f);
            return;
         end
         e = due_q.pop_front();
         checked++;
         if (v !== e.crc || f !== e.fin) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: beat %0d crc exp %h got %h, final exp %b got %b",
                        checked, e.crc, v, e.fin, f);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_crc_value;
   logic        rsp_crc_final;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = MODE_CRC32;

   crc_tracker  crc_book;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          beats_sent = 0;
   int          msgs_closed = 0;
   int          idle_cycles = 0;
   int          last_pct;
   mode_type    seg_modes[3] = '{MODE_CRC8, MODE_CRC32, MODE_CRC64};

   multi_width_crc_engine i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value),
      .rsp_crc_final (rsp_crc_final),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         crc_book.check_crc(rsp_crc_value, rsp_crc_final);
         if (rsp_crc_final) msgs_closed++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL multi_width_crc_engine");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic [7:0] d, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = d;
      req_last_byte = l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      crc_book.note_byte(d, l);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (crc_book.due_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] v);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      crc_book.select_mode(v);
   endtask

   initial begin
      crc_book = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h80, 1'b0);
      send_beat(8'h01, 1'b1);
      drain();
      write_mode(MODE_CRC8);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h55, 1'b0);
      drain();
      write_mode(MODE_UNUSED);
      send_beat(8'hAA, 1'b1);
      drain();
      write_mode(MODE_CRC64);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h01, 1'b1);
      send_beat(8'h80, 1'b1);
      send_beat(8'h12, 1'b0);
      drain();
      write_mode(MODE_CRC64);
      send_beat(8'h34, 1'b1);
      drain();
      write_mode(MODE_CRC32);
      send_beat(8'hA5, 1'b0);
      drain();
      write_mode(MODE_CRC8);
      send_beat(8'h5A, 1'b1);

      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         drain();
         write_mode(seg_modes[seg % 3]);
         if (seg % 4 == 3) write_mode(MODE_UNUSED);
         case (seg % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         last_pct = (seg % 2) ? 12 : 45;
         for (int i = 0; i < SEG_BEATS; i++) begin
            if (seg == 0 && i == 60) hold_toggle = ~hold_toggle;
            if (seg == 5 && i == 75) drain();
            send_beat(8'($urandom_range(255)), $urandom_range(99) < last_pct);
         end
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drain();
      $display("Summary: %0d beats sent, %0d checked, %0d messages closed over CRC-8/32/64,",
               beats_sent, crc_book.checked, msgs_closed);
      $display("         four idle patterns, a long response hold and mode writes");
      if (crc_book.mismatches == 0 && crc_book.due_q.size() == 0) begin
         $display("PASS multi_width_crc_engine");
      end else begin
         $display("FAIL multi_width_crc_engine");
      end
      $finish;
   end

endmodule

// ===== multi_width_crc_engine.f =====
src/mcrc_pkg.sv
src/mcrc_fold.sv
src/multi_width_crc_engine.sv
tb/sv/multi_width_crc_engine_tb.sv
